@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the spanning tree engine.
// No dependencies; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/core/sbst_pkg.sv @@
// Package of the spanning tree engine: sizes, field types.
// No dependencies.
package sbst_pkg;
    localparam int MAX_VERTICES = 256;
    localparam int MAX_EDGES = 1024;
    localparam int VERTEX_BITS = 8;
    localparam int WEIGHT_BITS = 16;
    localparam int SUM_BITS = 24;
    localparam int CFG_BITS = 9;
    typedef struct packed {
        logic [VERTEX_BITS-1:0] edge_from;
        logic [VERTEX_BITS-1:0] edge_to;
        logic signed [WEIGHT_BITS-1:0] edge_weight;
        logic last_edge;
    } edge_word_t;
    typedef struct packed {
        logic signed [SUM_BITS-1:0] tree_weight;
        logic signed [SUM_BITS-1:0] second_weight;
        logic graph_spans;
        logic second_found;
    } result_word_t;
endpackage

@@ rtl/core/sbst_if.sv @@
// Valid/ready channel interfaces for edge and result words.
// Depends on sbst_pkg.
interface sbst_edge_if;
    import sbst_pkg::*;
    logic valid;
    logic ready;
    edge_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sbst_result_if;
    import sbst_pkg::*;
    logic valid;
    logic ready;
    result_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/second_best_spanning_tree_top.sv @@
// Top level of the second best spanning tree engine.
// Depends on sbst_pkg, sbst_if, sbst_ram and assert_macros.svh.
//
//  channel   dir  word            handshake
//  edges     in   edge_word_t     valid/ready
//  result    out  result_word_t   valid/ready
//  cfg       in   vertex_count    cfg_we, no wait
//
// Ready stays high while edges load, so one edge word is taken per cycle; words
// past MAX_EDGES are not stored. After the last edge: an insertion sort by
// ascending weight, then one Kruskal pass for the tree and one per tree edge
// with that edge skipped, each led by a union-find clearing sweep over all
// MAX_VERTICES entries; find walks the parent memory with path halving. Ready
// stays low until the result word is taken. Reset clears the control state;
// the memories hold no reset values.
`include "assert_macros.svh"
module second_best_spanning_tree_top #(
    parameter int MAX_VERTICES = sbst_pkg::MAX_VERTICES,
    parameter int MAX_EDGES = sbst_pkg::MAX_EDGES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [sbst_pkg::CFG_BITS-1:0] cfg_wdata,
    sbst_edge_if.sink                 edges,
    sbst_result_if.source             result
);
    import sbst_pkg::*;

    localparam int EB = $clog2(MAX_EDGES);
    localparam int CB = EB + 1;
    localparam int VB = $clog2(MAX_VERTICES);
    localparam int NB = VB + 1;
    localparam int RB = 5;

    // States.
    localparam logic [4:0] S_LOAD = 5'd0;
    localparam logic [4:0] S_SORT_I = 5'd1;
    localparam logic [4:0] S_SORT_RK = 5'd2;
    localparam logic [4:0] S_SORT_RJ = 5'd3;
    localparam logic [4:0] S_SORT_CMP = 5'd4;
    localparam logic [4:0] S_SORT_CMP2 = 5'd5;
    localparam logic [4:0] S_CLEAR = 5'd6;
    localparam logic [4:0] S_EDGE = 5'd7;
    localparam logic [4:0] S_EDGE_R = 5'd8;
    localparam logic [4:0] S_EDGE_D = 5'd9;
    localparam logic [4:0] S_FIND = 5'd10;
    localparam logic [4:0] S_FIND_W = 5'd11;
    localparam logic [4:0] S_JOIN_RA = 5'd12;
    localparam logic [4:0] S_JOIN_RB = 5'd13;
    localparam logic [4:0] S_JOIN_W = 5'd14;
    localparam logic [4:0] S_PASS_END = 5'd15;
    localparam logic [4:0] S_NEXT_T = 5'd16;
    localparam logic [4:0] S_OUT = 5'd17;
    localparam logic [4:0] S_SORT_MV = 5'd18;
    localparam logic [4:0] S_FIND_W2 = 5'd19;

    logic [4:0] state_reg, state_next;
    logic [CFG_BITS-1:0] vcount_reg;
    logic [CB-1:0] ecount_reg, ecount_next;
    logic [CB-1:0] si_reg, si_next, sj_reg, sj_next;
    logic signed [WEIGHT_BITS-1:0] wk_reg, wk_next;
    logic [EB-1:0] sprev_reg, sprev_next;
    logic [NB-1:0] nv_reg, nv_next;
    logic [VB-1:0] vi_reg, vi_next;
    logic [CB-1:0] pos_reg, pos_next;
    logic [EB-1:0] cur_reg, cur_next;
    logic [VB-1:0] eb_reg, eb_next;
    logic signed [WEIGHT_BITS-1:0] ew_reg, ew_next;
    logic [VB-1:0] fv_reg, fv_next;
    logic side_reg, side_next;
    logic [VB-1:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [RB-1:0] rka_reg, rka_next;
    logic [NB-1:0] joined_reg, joined_next, tcount_reg, tcount_next;
    logic signed [SUM_BITS+CB:0] sum_reg, sum_next;
    logic first_reg, first_next;
    logic [NB-1:0] ti_reg, ti_next;
    logic [EB-1:0] skip_reg, skip_next;
    logic signed [SUM_BITS+CB:0] first_sum_reg, first_sum_next, best_reg, best_next;
    logic found_reg, found_next, spans_reg, spans_next;

    // Memory ports.
    logic es_we, so_we, pa_we, rk_we, tl_we;
    logic [EB-1:0] es_addr, so_addr, tl_wd;
    logic [31:0] es_wd, es_rd;
    logic [EB-1:0] so_wd, so_rd, tl_rd;
    logic [VB-1:0] pa_addr, pa_wd, pa_rd, rk_addr, tl_addr;
    logic [RB-1:0] rk_wd, rk_rd;

    sbst_ram #(.WIDTH(32), .DEPTH(MAX_EDGES)) u_edges (
        .clk(clk), .we(es_we), .addr(es_addr), .wdata(es_wd), .rdata(es_rd));
    sbst_ram #(.WIDTH(EB), .DEPTH(MAX_EDGES)) u_order (
        .clk(clk), .we(so_we), .addr(so_addr), .wdata(so_wd), .rdata(so_rd));
    sbst_ram #(.WIDTH(VB), .DEPTH(MAX_VERTICES)) u_parent (
        .clk(clk), .we(pa_we), .addr(pa_addr), .wdata(pa_wd), .rdata(pa_rd));
    sbst_ram #(.WIDTH(RB), .DEPTH(MAX_VERTICES)) u_rank (
        .clk(clk), .we(rk_we), .addr(rk_addr), .wdata(rk_wd), .rdata(rk_rd));
    sbst_ram #(.WIDTH(EB), .DEPTH(MAX_VERTICES)) u_tree (
        .clk(clk), .we(tl_we), .addr(tl_addr), .wdata(tl_wd), .rdata(tl_rd));

    logic signed [WEIGHT_BITS-1:0] rd_w;
    logic [VERTEX_BITS-1:0] rd_from, rd_to;
    logic [CFG_BITS-1:0] nv_raw;
    logic signed [SUM_BITS+CB:0] w_ext;
    assign rd_w = es_rd[WEIGHT_BITS-1:0];
    assign rd_to = es_rd[WEIGHT_BITS +: VERTEX_BITS];
    assign rd_from = es_rd[WEIGHT_BITS+VERTEX_BITS +: VERTEX_BITS];
    assign w_ext = {{(SUM_BITS+CB+1-WEIGHT_BITS){ew_reg[WEIGHT_BITS-1]}}, ew_reg};

    // Saturate a wide sum to the result width.
    function automatic logic [SUM_BITS-1:0] sat(input logic signed [SUM_BITS+CB:0] v);
        logic signed [SUM_BITS+CB:0] hi, lo;
        hi = (SUM_BITS+CB+1)'(8388607);
        lo = -(SUM_BITS+CB+1)'(8388608);
        if (v > hi) return hi[SUM_BITS-1:0];
        if (v < lo) return lo[SUM_BITS-1:0];
        return v[SUM_BITS-1:0];
    endfunction

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= CFG_BITS'(256);
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_wdata;
        end
    end

    assign nv_raw = (vcount_reg == '0) ? CFG_BITS'(1)
        : ((32'(vcount_reg) > MAX_VERTICES) ? CFG_BITS'(MAX_VERTICES) : vcount_reg);
    assign edges.ready = (state_reg == S_LOAD);
    assign result.valid = (state_reg == S_OUT);
    assign result.data.tree_weight = sat(first_sum_reg);
    assign result.data.second_weight = found_reg ? sat(best_reg) : '0;
    assign result.data.graph_spans = spans_reg;
    assign result.data.second_found = found_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        ecount_next = ecount_reg;
        si_next = si_reg; sj_next = sj_reg; wk_next = wk_reg; sprev_next = sprev_reg;
        nv_next = nv_reg; vi_next = vi_reg; pos_next = pos_reg; cur_next = cur_reg;
        eb_next = eb_reg; ew_next = ew_reg;
        fv_next = fv_reg; side_next = side_reg;
        ra_next = ra_reg; rb_next = rb_reg; rka_next = rka_reg;
        joined_next = joined_reg; tcount_next = tcount_reg; sum_next = sum_reg;
        first_next = first_reg; ti_next = ti_reg; skip_next = skip_reg;
        first_sum_next = first_sum_reg; best_next = best_reg;
        found_next = found_reg; spans_next = spans_reg;
        es_we = 1'b0; es_addr = '0; es_wd = '0;
        so_we = 1'b0; so_addr = '0; so_wd = '0;
        pa_we = 1'b0; pa_addr = '0; pa_wd = '0;
        rk_we = 1'b0; rk_addr = '0; rk_wd = '0;
        tl_we = 1'b0; tl_addr = '0; tl_wd = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (edges.valid)
                begin
                    es_addr = ecount_reg[EB-1:0];
                    es_wd = {edges.data.edge_from, edges.data.edge_to,
                             edges.data.edge_weight};
                    if (32'(ecount_reg) < MAX_EDGES)
                    begin
                        es_we = 1'b1;
                        ecount_next = ecount_reg + 1'b1;
                    end
                    if (edges.data.last_edge)
                    begin
                        nv_next = NB'(nv_raw);
                        si_next = '0;
                        state_next = S_SORT_I;
                    end
                end
            end
            // Insertion sort: fetch weight of store entry i.
            S_SORT_I:
            begin
                if (si_reg == ecount_reg)
                begin
                    first_next = 1'b1;
                    skip_next = '0;
                    vi_next = '0;
                    state_next = S_CLEAR;
                end
                else
                begin
                    es_addr = si_reg[EB-1:0];
                    sj_next = si_reg;
                    state_next = S_SORT_RK;
                end
            end
            S_SORT_RK:
            begin
                wk_next = rd_w;
                state_next = S_SORT_RJ;
            end
            S_SORT_RJ:
            begin
                if (sj_reg == '0)
                begin
                    so_we = 1'b1; so_addr = '0; so_wd = si_reg[EB-1:0];
                    si_next = si_reg + 1'b1;
                    state_next = S_SORT_I;
                end
                else
                begin
                    so_addr = EB'(sj_reg - 1'b1);
                    state_next = S_SORT_CMP;
                end
            end
            S_SORT_CMP:
            begin
                sprev_next = so_rd;
                es_addr = so_rd;
                state_next = S_SORT_CMP2;
            end
            S_SORT_CMP2:
            begin
                if (rd_w > wk_reg)
                begin
                    state_next = S_SORT_MV;
                end
                else
                begin
                    so_we = 1'b1; so_addr = sj_reg[EB-1:0]; so_wd = si_reg[EB-1:0];
                    si_next = si_reg + 1'b1;
                    state_next = S_SORT_I;
                end
            end
            S_SORT_MV:
            begin
                so_we = 1'b1; so_addr = sj_reg[EB-1:0]; so_wd = sprev_reg;
                sj_next = sj_reg - 1'b1;
                state_next = S_SORT_RJ;
            end
            // Union-find clearing sweep.
            S_CLEAR:
            begin
                pa_we = 1'b1; pa_addr = vi_reg; pa_wd = vi_reg;
                rk_we = 1'b1; rk_addr = vi_reg; rk_wd = '0;
                vi_next = vi_reg + 1'b1;
                if (32'(vi_reg) == MAX_VERTICES - 1)
                begin
                    pos_next = '0; joined_next = '0; sum_next = '0;
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                if (pos_reg == ecount_reg)
                begin
                    state_next = S_PASS_END;
                end
                else
                begin
                    so_addr = pos_reg[EB-1:0];
                    state_next = S_EDGE_R;
                end
            end
            S_EDGE_R:
            begin
                cur_next = so_rd;
                es_addr = so_rd;
                state_next = S_EDGE_D;
            end
            S_EDGE_D:
            begin
                eb_next = VB'(rd_to); ew_next = rd_w;
                pos_next = pos_reg + 1'b1;
                if ((!first_reg && cur_reg == skip_reg) || 32'(rd_from) >= 32'(nv_reg)
                    || 32'(rd_to) >= 32'(nv_reg))
                begin
                    state_next = S_EDGE;
                end
                else
                begin
                    fv_next = VB'(rd_from); side_next = 1'b0;
                    state_next = S_FIND;
                end
            end
            // Find with path halving: read parent of v.
            S_FIND:
            begin
                pa_addr = fv_reg;
                state_next = S_FIND_W;
            end
            S_FIND_W:
            begin
                if (pa_rd == fv_reg)
                begin
                    if (!side_reg)
                    begin
                        ra_next = fv_reg; fv_next = eb_reg; side_next = 1'b1;
                        state_next = S_FIND;
                    end
                    else
                    begin
                        rb_next = fv_reg;
                        if (ra_reg == fv_reg)
                        begin
                            state_next = S_EDGE;
                        end
                        else
                        begin
                            rk_addr = ra_reg;
                            state_next = S_JOIN_RA;
                        end
                    end
                end
                else
                begin
                    pa_addr = pa_rd;
                    state_next = S_FIND_W2;
                end
            end
            S_FIND_W2:
            begin
                pa_we = 1'b1; pa_addr = fv_reg; pa_wd = pa_rd;
                fv_next = pa_rd;
                state_next = S_FIND;
            end
            S_JOIN_RA:
            begin
                rka_next = rk_rd;
                rk_addr = rb_reg;
                state_next = S_JOIN_RB;
            end
            S_JOIN_RB:
            begin
                if (rka_reg > rk_rd)
                begin
                    pa_we = 1'b1; pa_addr = rb_reg; pa_wd = ra_reg;
                end
                else if (rka_reg < rk_rd)
                begin
                    pa_we = 1'b1; pa_addr = ra_reg; pa_wd = rb_reg;
                end
                else
                begin
                    pa_we = 1'b1; pa_addr = rb_reg; pa_wd = ra_reg;
                    rk_we = 1'b1; rk_addr = ra_reg; rk_wd = rka_reg + 1'b1;
                end
                state_next = S_JOIN_W;
            end
            S_JOIN_W:
            begin
                if (first_reg && 32'(joined_reg) < MAX_VERTICES)
                begin
                    tl_we = 1'b1; tl_addr = joined_reg[VB-1:0]; tl_wd = cur_reg;
                end
                joined_next = joined_reg + 1'b1;
                sum_next = sum_reg + w_ext;
                state_next = S_EDGE;
            end
            S_PASS_END:
            begin
                if (first_reg)
                begin
                    first_sum_next = sum_reg;
                    tcount_next = joined_reg;
                    spans_next = (joined_reg == nv_reg - 1'b1);
                    found_next = 1'b0; best_next = '0;
                    ti_next = '0;
                end
                else
                begin
                    if (joined_reg == nv_reg - 1'b1)
                    begin
                        if (!found_reg || sum_reg < best_reg) best_next = sum_reg;
                        found_next = 1'b1;
                    end
                    ti_next = ti_reg + 1'b1;
                end
                first_next = 1'b0;
                state_next = S_NEXT_T;
            end
            S_NEXT_T:
            begin
                if (ti_reg >= tcount_reg || 32'(ti_reg) >= MAX_VERTICES)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    tl_addr = ti_reg[VB-1:0];
                    state_next = S_CLEAR;
                    vi_next = '0;
                end
            end
            S_OUT:
            begin
                if (result.ready)
                begin
                    ecount_next = '0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
        if (state_reg == S_CLEAR && vi_reg == '0 && !first_reg)
        begin
            skip_next = tl_rd;
        end
    end

    // Control and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            ecount_reg <= '0;
            found_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ecount_reg <= ecount_next;
            found_reg <= found_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg <= si_next; sj_reg <= sj_next; wk_reg <= wk_next; sprev_reg <= sprev_next;
        nv_reg <= nv_next; vi_reg <= vi_next; pos_reg <= pos_next; cur_reg <= cur_next;
        eb_reg <= eb_next; ew_reg <= ew_next;
        fv_reg <= fv_next; side_reg <= side_next;
        ra_reg <= ra_next; rb_reg <= rb_next; rka_reg <= rka_next;
        joined_reg <= joined_next; tcount_reg <= tcount_next; sum_reg <= sum_next;
        ti_reg <= ti_next; skip_reg <= skip_next;
        first_sum_reg <= first_sum_next; best_reg <= best_next; spans_reg <= spans_next;
    end

    // Checks.
    `ASSERT_IMPLIES(a_excl, clk, rst_n, result.valid, !edges.ready)
    `ASSERT_NEXT(a_hold, clk, rst_n, result.valid && !result.ready, result.valid)
    `ASSERT_IMPLIES(a_count, clk, rst_n, 1'b1, 32'(ecount_reg) <= MAX_EDGES)
    `ASSERT_IMPLIES(a_found, clk, rst_n, result.valid && !result.data.second_found,
        result.data.second_weight == '0)
endmodule

@@ rtl/core/sbst_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module sbst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
